### sv/rv32_pkg.sv
// Package for the RV32IM execute unit: operation codes, pipeline types and widths.
// Used by rv32im_execute_unit and its testbench. No dependencies.
package rv32_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned DIV_STEPS = XLEN;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLL = 6'd2, OP_SRL = 6'd3, OP_SRA = 6'd4,
    OP_AND = 6'd5, OP_OR = 6'd6, OP_XOR = 6'd7, OP_SLT = 6'd8, OP_SLTU = 6'd9,
    OP_LUI = 6'd10, OP_AUIPC = 6'd11,
    OP_MUL = 6'd12, OP_MULH = 6'd13, OP_MULHSU = 6'd14, OP_MULHU = 6'd15,
    OP_DIV = 6'd16, OP_DIVU = 6'd17, OP_REM = 6'd18, OP_REMU = 6'd19,
    OP_BEQ = 6'd20, OP_BNE = 6'd21, OP_BLT = 6'd22, OP_BGE = 6'd23,
    OP_BLTU = 6'd24, OP_BGEU = 6'd25, OP_JAL = 6'd26, OP_JALR = 6'd27,
    OP_LB = 6'd28, OP_LH = 6'd29, OP_LW = 6'd30, OP_LBU = 6'd31, OP_LHU = 6'd32,
    OP_SB = 6'd33, OP_SH = 6'd34, OP_SW = 6'd35,
    OP_FENCE = 6'd36, OP_FENCE_I = 6'd37, OP_ECALL = 6'd38, OP_EBREAK = 6'd39,
    OP_INVALID = 6'd40
  } op_e;

  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
  localparam logic [XLEN-1:0] JALR_MASK = ~32'd1;

  // Registered copy of one accepted beat.
  typedef struct packed {
    logic [5:0]      op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] pc;
    logic            use_imm;
  } req_t;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [5:0]        op;
    logic [XLEN-1:0]   a;
    logic [XLEN-1:0]   b;
    logic [XLEN-1:0]   res;
    logic              rv;
    logic              ill;
    logic [XLEN-1:0]   npc;
    logic [XLEN-1:0]   saddr;
    logic [XLEN-1:0]   sval;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0]   corr;
    logic              neg_q;
    logic              neg_r;
    logic [XLEN-1:0]   rem;
    logic [XLEN-1:0]   quo;
    logic [XLEN-1:0]   dvs;
  } pipe_t;

  // Result beat: flags travel in tuser.
  typedef struct packed {
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] npc;
    logic [XLEN-1:0] saddr;
    logic [XLEN-1:0] sval;
    logic            rv;
    logic            ill;
  } rsp_t;

endpackage

### sv/rv32im_execute_unit.sv
// Top level of the RV32IM execute unit: ALU, branch, multiply and a pipelined divider.
// Depends on rv32_pkg.
//
//  channel  | direction | tdata (low bit up)                            | tuser
//  s_axis   | in        | req_type, operand_a, operand_b, immediate,    | use_immediate
//           |           | inst_pc, 2 zero bits                          |
//  m_axis   | out       | result_value, next_pc, store_addr, store_value| result_valid, illegal_op
//
// Every beat passes an input register, a decode and multiply stage, 32 restoring divide
// stages (one quotient bit each) and an output register before its result shows. A new beat
// is accepted every cycle while the output is not stalled. When the output beat is not
// taken the whole pipeline holds. Reset clears all stage valid bits.
module rv32im_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // req_type, operand_a, operand_b, immediate, inst_pc
  input  logic         s_axis_tuser,   // use_immediate
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_value, next_pc, store_addr, store_value
  output logic [1:0]   m_axis_tuser    // result_valid, illegal_op
);

  localparam int unsigned N = rv32_pkg::DIV_STEPS;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input register.
  logic           in_vld_q;
  rv32_pkg::req_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.op      <= s_axis_tdata[5:0];
      in_q.a       <= s_axis_tdata[37:6];
      in_q.b       <= s_axis_tdata[69:38];
      in_q.imm     <= s_axis_tdata[101:70];
      in_q.pc      <= s_axis_tdata[133:102];
      in_q.use_imm <= s_axis_tuser;
    end
  end

  // Decode stage: ALU, branches, stores, multiply and divider operand setup.
  rv32_pkg::pipe_t prep_d;

  always_comb begin
    logic [31:0] ob;
    logic        taken;
    logic        sgn;
    ob     = in_q.use_imm ? in_q.imm : in_q.b;
    taken  = 1'b0;
    prep_d = '0;
    prep_d.op    = in_q.op;
    prep_d.a     = in_q.a;
    prep_d.b     = in_q.b;
    prep_d.npc   = in_q.pc + rv32_pkg::PC_STEP;
    prep_d.rv    = (in_q.op <= rv32_pkg::OP_REMU);
    prep_d.prod  = {32'd0, in_q.a} * {32'd0, in_q.b};
    prep_d.corr  = (in_q.a[31] ? in_q.b : 32'd0);
    if (in_q.op == rv32_pkg::OP_MULH) begin
      prep_d.corr = prep_d.corr + (in_q.b[31] ? in_q.a : 32'd0);
    end
    sgn          = (in_q.op == rv32_pkg::OP_DIV) || (in_q.op == rv32_pkg::OP_REM);
    prep_d.neg_q = sgn && (in_q.a[31] ^ in_q.b[31]);
    prep_d.neg_r = sgn && in_q.a[31];
    prep_d.rem   = '0;
    prep_d.quo   = (sgn && in_q.a[31]) ? (32'd0 - in_q.a) : in_q.a;
    prep_d.dvs   = (sgn && in_q.b[31]) ? (32'd0 - in_q.b) : in_q.b;
    case (in_q.op)
      rv32_pkg::OP_ADD:   prep_d.res = in_q.a + ob;
      rv32_pkg::OP_SUB:   prep_d.res = in_q.a - in_q.b;
      rv32_pkg::OP_SLL:   prep_d.res = in_q.a << ob[4:0];
      rv32_pkg::OP_SRL:   prep_d.res = in_q.a >> ob[4:0];
      rv32_pkg::OP_SRA:   prep_d.res = 32'($signed(in_q.a) >>> ob[4:0]);
      rv32_pkg::OP_AND:   prep_d.res = in_q.a & ob;
      rv32_pkg::OP_OR:    prep_d.res = in_q.a | ob;
      rv32_pkg::OP_XOR:   prep_d.res = in_q.a ^ ob;
      rv32_pkg::OP_SLT:   prep_d.res = {31'd0, $signed(in_q.a) < $signed(ob)};
      rv32_pkg::OP_SLTU:  prep_d.res = {31'd0, in_q.a < ob};
      rv32_pkg::OP_LUI:   prep_d.res = in_q.imm;
      rv32_pkg::OP_AUIPC: prep_d.res = in_q.pc + in_q.imm;
      rv32_pkg::OP_BEQ:   taken = (in_q.a == in_q.b);
      rv32_pkg::OP_BNE:   taken = (in_q.a != in_q.b);
      rv32_pkg::OP_BLT:   taken = $signed(in_q.a) < $signed(in_q.b);
      rv32_pkg::OP_BGE:   taken = !($signed(in_q.a) < $signed(in_q.b));
      rv32_pkg::OP_BLTU:  taken = (in_q.a < in_q.b);
      rv32_pkg::OP_BGEU:  taken = (in_q.a >= in_q.b);
      rv32_pkg::OP_JAL: begin
        prep_d.res = in_q.pc + rv32_pkg::PC_STEP;
        prep_d.rv  = 1'b1;
        prep_d.npc = in_q.pc + in_q.imm;
      end
      rv32_pkg::OP_JALR: begin
        prep_d.res = in_q.pc + rv32_pkg::PC_STEP;
        prep_d.rv  = 1'b1;
        prep_d.npc = (in_q.a + in_q.imm) & rv32_pkg::JALR_MASK;
      end
      rv32_pkg::OP_SB, rv32_pkg::OP_SH, rv32_pkg::OP_SW: begin
        prep_d.saddr = in_q.a + in_q.imm;
        prep_d.sval  = in_q.b;
      end
      default: prep_d.ill = (in_q.op >= rv32_pkg::OP_INVALID);
    endcase
    if (taken) begin
      prep_d.npc = in_q.pc + in_q.imm;
    end
  end

  logic            prep_vld_q;
  rv32_pkg::pipe_t prep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (adv) begin
      prep_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_q <= prep_d;
    end
  end

  // Restoring divider: each stage shifts in one dividend bit and decides one quotient bit.
  logic            dv_vld_q [N];
  rv32_pkg::pipe_t dv_q     [N];
  rv32_pkg::pipe_t dv_d     [N];

  for (genvar i = 0; i < N; i++) begin : g_div
    rv32_pkg::pipe_t src;
    logic            src_vld;
    if (i == 0) begin : g_first
      assign src     = prep_q;
      assign src_vld = prep_vld_q;
    end else begin : g_next
      assign src     = dv_q[i-1];
      assign src_vld = dv_vld_q[i-1];
    end

    always_comb begin
      logic [32:0] sh;
      logic [32:0] diff;
      sh       = {src.rem, src.quo[31]};
      diff     = sh - {1'b0, src.dvs};
      dv_d[i]  = src;
      dv_d[i].quo = {src.quo[30:0], !diff[32]};
      dv_d[i].rem = diff[32] ? sh[31:0] : diff[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // Output stage: pick the multiply, divide or decoded result and apply the divide signs.
  rv32_pkg::pipe_t fin;
  rv32_pkg::rsp_t  out_d;
  rv32_pkg::rsp_t  out_q;
  logic            out_vld_q;

  assign fin = dv_q[N-1];

  always_comb begin
    logic [31:0] q_s;
    logic [31:0] r_s;
    q_s = fin.neg_q ? (32'd0 - fin.quo) : fin.quo;
    r_s = fin.neg_r ? (32'd0 - fin.rem) : fin.rem;
    out_d.res   = fin.res;
    out_d.npc   = fin.npc;
    out_d.saddr = fin.saddr;
    out_d.sval  = fin.sval;
    out_d.rv    = fin.rv;
    out_d.ill   = fin.ill;
    case (fin.op)
      rv32_pkg::OP_MUL:    out_d.res = fin.prod[31:0];
      rv32_pkg::OP_MULH,
      rv32_pkg::OP_MULHSU: out_d.res = fin.prod[63:32] - fin.corr;
      rv32_pkg::OP_MULHU:  out_d.res = fin.prod[63:32];
      rv32_pkg::OP_DIV,
      rv32_pkg::OP_DIVU:   out_d.res = (fin.b == 32'd0) ? 32'hFFFF_FFFF : q_s;
      rv32_pkg::OP_REM,
      rv32_pkg::OP_REMU:   out_d.res = (fin.b == 32'd0) ? fin.a : r_s;
      default:             out_d.res = fin.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.sval, out_q.saddr, out_q.npc, out_q.res};
  assign m_axis_tuser  = {out_q.ill, out_q.rv};

endmodule

### sv/rv32im_execute_unit_chk.sv
// Port-level checker for the RV32IM execute unit, bound to the top level.
// Depends on the top level's port list only.
module rv32im_execute_unit_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // The pipeline accepts exactly when the output can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // An illegal operation never writes a register.
  a_ill_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[31:0] == 32'd0)
    else $error("illegal operation produced a result");

  // An illegal operation leaves the store fields empty.
  a_ill_nostore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[127:64] == 64'd0)
    else $error("illegal operation produced a store");

endmodule

bind rv32im_execute_unit rv32im_execute_unit_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/tb.sv
// Self-checking bench for rv32im_execute_unit: directed micro-ops, then random ones.
// Expected results come from an in-bench execute model; depends on rv32_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY   = 35;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned LONG_HOLD = 200;

  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] pc;
    logic        use_imm;
  } uop_t;

  typedef struct packed {
    logic [31:0] res;
    logic        rv;
    logic [31:0] npc;
    logic [31:0] saddr;
    logic [31:0] sval;
    logic        ill;
  } exe_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;   // req_type, operand_a, operand_b, immediate, inst_pc
  logic         s_axis_tuser;   // use_immediate
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // result_value, next_pc, store_addr, store_value
  logic [1:0]   m_axis_tuser;   // result_valid, illegal_op

  exe_t        expected_q[$];
  int unsigned errors;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_cycles;
  int unsigned idle_cycles;

  rv32im_execute_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock and a single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic signed_lt(logic [31:0] x, logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // Execute model: what one micro-op must produce.
  function automatic exe_t predict_uop(uop_t u);
    exe_t        e;
    logic [31:0] ob;
    logic [63:0] pp;
    logic        taken;
    e     = '0;
    ob    = u.use_imm ? u.imm : u.b;
    e.npc = u.pc + rv32_pkg::PC_STEP;
    e.rv  = (u.op <= rv32_pkg::OP_REMU);
    taken = 1'b0;
    pp    = {32'd0, u.a} * {32'd0, u.b};
    case (u.op)
      rv32_pkg::OP_ADD:    e.res = u.a + ob;
      rv32_pkg::OP_SUB:    e.res = u.a - u.b;
      rv32_pkg::OP_SLL:    e.res = u.a << ob[4:0];
      rv32_pkg::OP_SRL:    e.res = u.a >> ob[4:0];
      rv32_pkg::OP_SRA:    e.res = $signed(u.a) >>> ob[4:0];
      rv32_pkg::OP_AND:    e.res = u.a & ob;
      rv32_pkg::OP_OR:     e.res = u.a | ob;
      rv32_pkg::OP_XOR:    e.res = u.a ^ ob;
      rv32_pkg::OP_SLT:    e.res = {31'd0, signed_lt(u.a, ob)};
      rv32_pkg::OP_SLTU:   e.res = {31'd0, u.a < ob};
      rv32_pkg::OP_LUI:    e.res = u.imm;
      rv32_pkg::OP_AUIPC:  e.res = u.pc + u.imm;
      rv32_pkg::OP_MUL:    e.res = pp[31:0];
      rv32_pkg::OP_MULH:
        e.res = pp[63:32] - (u.a[31] ? u.b : 32'd0) - (u.b[31] ? u.a : 32'd0);
      rv32_pkg::OP_MULHSU: e.res = pp[63:32] - (u.a[31] ? u.b : 32'd0);
      rv32_pkg::OP_MULHU:  e.res = pp[63:32];
      rv32_pkg::OP_DIV: begin
        if (u.b == 0) e.res = '1;
        else if (u.a == 32'h8000_0000 && u.b == '1) e.res = u.a;
        else e.res = $signed(u.a) / $signed(u.b);
      end
      rv32_pkg::OP_DIVU:   e.res = (u.b == 0) ? '1 : u.a / u.b;
      rv32_pkg::OP_REM: begin
        if (u.b == 0) e.res = u.a;
        else if (u.a == 32'h8000_0000 && u.b == '1) e.res = '0;
        else e.res = $signed(u.a) % $signed(u.b);
      end
      rv32_pkg::OP_REMU:   e.res = (u.b == 0) ? u.a : u.a % u.b;
      rv32_pkg::OP_BEQ:    taken = (u.a == u.b);
      rv32_pkg::OP_BNE:    taken = (u.a != u.b);
      rv32_pkg::OP_BLT:    taken = signed_lt(u.a, u.b);
      rv32_pkg::OP_BGE:    taken = !signed_lt(u.a, u.b);
      rv32_pkg::OP_BLTU:   taken = (u.a < u.b);
      rv32_pkg::OP_BGEU:   taken = (u.a >= u.b);
      rv32_pkg::OP_JAL: begin
        e.res = u.pc + rv32_pkg::PC_STEP;
        e.rv  = 1'b1;
        e.npc = u.pc + u.imm;
      end
      rv32_pkg::OP_JALR: begin
        e.res = u.pc + rv32_pkg::PC_STEP;
        e.rv  = 1'b1;
        e.npc = (u.a + u.imm) & rv32_pkg::JALR_MASK;
      end
      rv32_pkg::OP_SB, rv32_pkg::OP_SH, rv32_pkg::OP_SW: begin
        e.saddr = u.a + u.imm;
        e.sval  = u.b;
      end
      default: e.ill = (u.op >= rv32_pkg::OP_INVALID);
    endcase
    if (taken) e.npc = u.pc + u.imm;
    return e;
  endfunction

  // Offer one micro-op with the current sender idle rate; returns once accepted.
  task automatic send_uop(uop_t u);
    while (snd_idle_pct != 0 && $urandom_range(99, 0) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, u.pc, u.imm, u.b, u.a, u.op};
    s_axis_tuser  <= u.use_imm;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.insert(expected_q.size(), predict_uop(u));
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver ready: random stalls, or a long hold when one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
    end
  end

  // Result checker: compares each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    exe_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tdata[63:32],
             m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tuser[1]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (got.res !== want.res) begin
          $display("%0t: result_value exp %h got %h", $time, want.res, got.res);
          errors++;
        end
        if (got.rv !== want.rv) begin
          $display("%0t: result_valid exp %b got %b", $time, want.rv, got.rv);
          errors++;
        end
        if (got.npc !== want.npc) begin
          $display("%0t: next_pc exp %h got %h", $time, want.npc, got.npc);
          errors++;
        end
        if (got.saddr !== want.saddr) begin
          $display("%0t: store_addr exp %h got %h", $time, want.saddr, got.saddr);
          errors++;
        end
        if (got.sval !== want.sval) begin
          $display("%0t: store_value exp %h got %h", $time, want.sval, got.sval);
          errors++;
        end
        if (got.ill !== want.ill) begin
          $display("%0t: illegal_op exp %b got %b", $time, want.ill, got.ill);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        expected_q.size() == 0 && !s_axis_tvalid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] corner_word();
    case ($urandom_range(7, 0))
      0: return 32'd0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      5: return $urandom_range(31, 0);
      default: return $urandom();
    endcase
  endfunction

  function automatic uop_t random_uop();
    uop_t u;
    u.op      = ($urandom_range(9, 0) == 0) ? 6'($urandom_range(63, 0))
                                            : 6'($urandom_range(rv32_pkg::OP_INVALID, 0));
    u.a       = corner_word();
    u.b       = ($urandom_range(7, 0) == 0) ? u.a : corner_word();
    u.imm     = corner_word();
    u.pc      = $urandom();
    u.use_imm = 1'($urandom_range(1, 0));
    return u;
  endfunction

  // Directed corners: every operation plus divide, shift, jump, store, multiply and illegal-op special cases.
  task automatic test_directed();
    uop_t u;
    send_uop('{rv32_pkg::OP_DIV, 32'h8000_0000, '1, 32'd0, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_REM, 32'h8000_0000, '1, 32'd0, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_DIV, 32'd7, 32'd0, 32'd0, '1, 1'b0});
    send_uop('{rv32_pkg::OP_DIVU, '1, 32'd0, 32'd0, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_REM, 32'hffff_fff9, 32'd0, '1, 32'd0, 1'b1});
    send_uop('{rv32_pkg::OP_REMU, 32'd9, 32'd0, 32'd0, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_SRA, 32'h8000_0000, 32'hffff_ffe3, 32'h20, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_SLL, '1, 32'd0, 32'h3f, 32'd0, 1'b1});
    send_uop('{rv32_pkg::OP_SUB, 32'd5, 32'd9, 32'd1, 32'd0, 1'b1});
    send_uop('{rv32_pkg::OP_JALR, '1, 32'd0, 32'd2, '1, 1'b0});
    send_uop('{rv32_pkg::OP_JAL, 32'd0, 32'd0, 32'h8000_0000, 32'hffff_fffc, 1'b0});
    send_uop('{rv32_pkg::OP_SW, '1, 32'h1234_5678, 32'd1, 32'd0, 1'b0});
    send_uop('{rv32_pkg::OP_MULH, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 1'b0});
    send_uop('{6'd63, '1, '1, '1, '1, 1'b1});
    for (int op = 0; op <= int'(rv32_pkg::OP_INVALID); op++) begin
      u    = random_uop();
      u.op = 6'(op);
      send_uop(u);
    end
    go_quiet();
  endtask

  // Random micro-ops under one idling profile.
  task automatic test_random(int unsigned n, int unsigned snd_pct, int unsigned rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (n) send_uop(random_uop());
    go_quiet();
  endtask

  // Receiver holds off for a long stretch while micro-ops keep coming.
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles  = LONG_HOLD;
    repeat (100) send_uop(random_uop());
    go_quiet();
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    errors        = 0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    hold_cycles   = 0;
    idle_cycles   = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_random(400, 7, 70);
    test_random(400, 70, 7);
    test_random(400, 0, 0);
    test_backpressure();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
